// ----- hdl/midi_chord_expander_top_defines.svh -----
// Assertion helpers shared by the chord expander RTL.
`ifndef MIDI_CHORD_EXPANDER_TOP_DEFINES_SVH
`define MIDI_CHORD_EXPANDER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CME_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cme_pkg.sv -----
package cme_pkg;

  localparam int CHORD_TONES  = 13;
  localparam int NOTE_COUNT   = 128;
  localparam int RESULT_LIMIT = 64;

  // op field codes
  localparam logic [1:0] OP_MIDI    = 2'd0;
  localparam logic [1:0] OP_UPDATE  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // status high nibbles
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_POLY_AT  = 4'hA;

  // register indexes
  localparam logic REG_CHORD_FLAGS = 1'b0;
  localparam logic REG_INVERSION   = 1'b1;

  // Position p of the full interval list 0,3,6,3,7,4,7,5,7,9,10,11,14 is present?
  function automatic logic tone_en(input logic [3:0] p, input logic [7:0] flags);
    logic en;
    case (p)
      4'd0:          en = 1'b1;
      4'd1, 4'd2:    en = flags[0];
      4'd3, 4'd4:    en = flags[1];
      4'd5, 4'd6:    en = flags[2];
      4'd7, 4'd8:    en = flags[3];
      4'd9:          en = flags[4];
      4'd10:         en = flags[5];
      4'd11:         en = flags[6];
      4'd12:         en = flags[7];
      default:       en = 1'b0;
    endcase
    return en;
  endfunction

  function automatic logic [3:0] tone_iv(input logic [3:0] p);
    logic [3:0] iv;
    case (p)
      4'd1, 4'd3:        iv = 4'd3;
      4'd2:              iv = 4'd6;
      4'd4, 4'd6, 4'd8:  iv = 4'd7;
      4'd5:              iv = 4'd4;
      4'd7:              iv = 4'd5;
      4'd9:              iv = 4'd9;
      4'd10:             iv = 4'd10;
      4'd11:             iv = 4'd11;
      4'd12:             iv = 4'd14;
      default:           iv = 4'd0;
    endcase
    return iv;
  endfunction

  function automatic logic [3:0] chord_len(input logic [7:0] flags);
    logic [3:0] n;
    n = 4'd1 + {2'b0, flags[0], 1'b0} + {2'b0, flags[1], 1'b0}
        + {2'b0, flags[2], 1'b0} + {2'b0, flags[3], 1'b0}
        + {3'b0, flags[4]} + {3'b0, flags[5]} + {3'b0, flags[6]} + {3'b0, flags[7]};
    return n;
  endfunction

endpackage

// ----- hdl/cme_ram.sv -----
module cme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; output holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/midi_chord_expander_top.sv -----
// MIDI chord expander. Each accepted item is a MIDI message (op 0), an update
// of all held chords (op 1) or a release of all chords (op 2); op 3 is ignored.
// A note-on with nonzero velocity turns its root into a chord built from
// chord_flags and inversion_count, takes over notes owned by other roots and
// sends one note-on per chord tone; note-off and poly aftertouch on a held root
// are replayed to its chord notes; other messages pass through. Up to MAX_ROOTS
// roots are held, further new roots are ignored. Results leave on the out
// channel, the final one of each item marked by last, at most 64 per item.
// Write configuration only while the block is idle, and send an update after
// changing it. One item is worked at a time by a sequencer around a single
// note adder and two memories (chord lists, note owners), each with one write
// and one read port; in_ready is high only when the sequencer is idle. A
// note-on removes each stolen note from its old owner's list; release-all
// scans all 128 notes; an update makes two 128-note scans. The owner memory
// is split in two banks, so an update builds the new ownership beside the old
// one and swaps banks at its end.
`include "midi_chord_expander_top_defines.svh"

module midi_chord_expander_top
  import cme_pkg::*;
#(
  parameter int MAX_ROOTS = 3
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] status_byte,
  input  logic [6:0] data_one,
  input  logic [6:0] data_two,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_status,
  output logic [6:0] out_data_one,
  output logic [6:0] out_data_two,
  output logic       last
);

  localparam int SLOT_W     = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
  localparam int SCNT_W     = $clog2(MAX_ROOTS + 1);
  localparam int OWN_W      = SCNT_W;
  localparam int LIST_DEPTH = MAX_ROOTS * CHORD_TONES;
  localparam int LA_W       = $clog2(LIST_DEPTH);
  localparam int OWN_DEPTH  = 2 * NOTE_COUNT;
  localparam int OA_W       = $clog2(OWN_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_BLD_DIV, S_BLD_TONE, S_TONE_OWN, S_RM_RD, S_RM_WR, S_NON_APP,
    S_UPD_SLOT, S_UPD_APP, S_OFF_RD, S_OFF_EM, S_AT_RD, S_AT_EM, S_PASS, S_REL,
    S_DOFF_CHK, S_DOFF_RO, S_DOFF_RN, S_DOFF_EM, S_DON_CHK, S_DON_RN, S_DON_RO,
    S_DON_EM, S_FLUSH
  } state_t;

  state_t state;

  // configuration
  logic [7:0] chord_flags;
  logic [3:0] inversion_count;

  // slot state
  logic [MAX_ROOTS-1:0] slot_valid;
  logic [6:0]           slot_root     [MAX_ROOTS];
  logic [6:0]           slot_velocity [MAX_ROOTS];
  logic [SLOT_W-1:0]    slot_age_rank [MAX_ROOTS];
  logic [3:0]           list_cnt      [MAX_ROOTS];
  logic [NOTE_COUNT-1:0] own_vld      [2];
  logic                 cur;
  logic [3:0]           last_channel;

  // item and sequencer registers
  logic [7:0]        st_r;
  logic [6:0]        d1_r;
  logic [6:0]        d2_r;
  logic              is_upd;
  logic [SLOT_W-1:0] cur_s;
  logic [SLOT_W-1:0] rm_s;
  logic [6:0]        bld_root;
  logic [3:0]        rem;
  logic [7:0]        q12;
  logic [3:0]        pos;
  logic [3:0]        idx;
  logic [6:0]        note;
  logic [3:0]        k;
  logic [3:0]        w;
  logic [7:0]        scan;
  logic [SCNT_W-1:0] rk;
  logic [SCNT_W-1:0] si;
  logic [OWN_W-1:0]  tmp;
  logic [6:0]        emit_cnt;

  // pending result, held back until it is known whether it is the last one
  logic       hold_vld;
  logic [7:0] hold_status;
  logic [6:0] hold_d1;
  logic [6:0] hold_d2;

  // memories
  logic             lw_we, lr_re;
  logic [LA_W-1:0]  lw_addr, lr_addr;
  logic [6:0]       lw_data, lr_data;
  logic             ow_we, or_re;
  logic [OA_W-1:0]  ow_addr, or_addr;
  logic [OWN_W-1:0] ow_data, or_data;

  cme_ram #(.WIDTH(7), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk(clk), .we(lw_we), .waddr(lw_addr), .wdata(lw_data),
    .re(lr_re), .raddr(lr_addr), .rdata(lr_data)
  );

  cme_ram #(.WIDTH(OWN_W), .DEPTH(OWN_DEPTH)) u_owner_ram (
    .clk(clk), .we(ow_we), .waddr(ow_addr), .wdata(ow_data),
    .re(or_re), .raddr(or_addr), .rdata(or_data)
  );

  function automatic logic [LA_W-1:0] laddr(input logic [SLOT_W-1:0] s,
                                            input logic [3:0] e);
    return LA_W'(32'(s) * CHORD_TONES + 32'(e));
  endfunction

  // ---------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------
  logic              bld_bank;
  logic [3:0]        ch_n;
  logic [8:0]        tone_sum;
  logic              pos_en;
  logic [3:0]        cnt_sel;
  logic [SLOT_W-1:0] cnt_idx;
  logic              old_v, new_v;
  logic              emit_ok, emit_req, emit_fire, can_push, flush_fire;
  logic [7:0]        em_status;
  logic [6:0]        em_d1, em_d2;
  logic [OWN_W-1:0]  cur_own;
  logic [3:0]        in_type;
  logic              f_hit, f_free;
  logic [SLOT_W-1:0] f_idx, f_free_idx;
  logic [SCNT_W-1:0] used;
  logic [SLOT_W-1:0] si_i;
  logic [SLOT_W-1:0] tmp_slot;

  assign in_ready  = (state == S_IDLE);
  assign bld_bank  = is_upd ? ~cur : cur;
  assign ch_n      = chord_len(chord_flags);
  assign pos_en    = tone_en(pos, chord_flags);
  assign tone_sum  = 9'(bld_root) + 9'(tone_iv(pos)) + 9'(q12)
                     + ((idx < rem) ? 9'd12 : 9'd0);
  assign cnt_idx   = (state == S_RM_RD || state == S_RM_WR) ? rm_s : cur_s;
  assign cnt_sel   = list_cnt[cnt_idx];
  assign old_v     = own_vld[cur][scan[6:0]];
  assign new_v     = own_vld[~cur][scan[6:0]];
  assign cur_own   = OWN_W'(cur_s) + OWN_W'(1);
  assign in_type   = status_byte[7:4];
  assign si_i      = si[SLOT_W-1:0];
  assign tmp_slot  = SLOT_W'(tmp - OWN_W'(1));

  assign can_push   = !out_valid || out_ready;
  assign emit_ok    = (emit_cnt >= 7'(RESULT_LIMIT)) || !hold_vld || can_push;
  assign emit_fire  = emit_req && emit_ok;
  assign flush_fire = (state == S_FLUSH) && hold_vld && can_push;

  // Slot lookup for the incoming note: first held slot with this root, first
  // free slot, and how many are in use.
  always_comb begin
    f_hit      = 1'b0;
    f_idx      = '0;
    f_free     = 1'b0;
    f_free_idx = '0;
    used       = '0;
    for (int s = MAX_ROOTS - 1; s >= 0; s--) begin
      if (slot_valid[s] && slot_root[s] == data_one) begin
        f_hit = 1'b1;
        f_idx = SLOT_W'(s);
      end
      if (!slot_valid[s]) begin
        f_free     = 1'b1;
        f_free_idx = SLOT_W'(s);
      end
    end
    for (int s = 0; s < MAX_ROOTS; s++) begin
      used = used + SCNT_W'(slot_valid[s]);
    end
  end

  // Memory strobes and the result offered in each state.
  always_comb begin
    emit_req  = 1'b0;
    em_status = '0;
    em_d1     = '0;
    em_d2     = '0;
    lw_we     = 1'b0;
    lw_addr   = '0;
    lw_data   = '0;
    lr_re     = 1'b0;
    lr_addr   = '0;
    ow_we     = 1'b0;
    ow_addr   = '0;
    ow_data   = '0;
    or_re     = 1'b0;
    or_addr   = '0;
    case (state)
      S_BLD_TONE: begin
        if (pos != 4'(CHORD_TONES) && pos_en && tone_sum[8:7] == 2'b00) begin
          or_re   = 1'b1;
          or_addr = {bld_bank, tone_sum[6:0]};
        end
      end
      S_RM_RD: begin
        if (k != cnt_sel) begin
          lr_re   = 1'b1;
          lr_addr = laddr(rm_s, k);
        end
      end
      S_RM_WR: begin
        if (lr_data != note) begin
          lw_we   = 1'b1;
          lw_addr = laddr(rm_s, w);
          lw_data = lr_data;
        end
      end
      S_NON_APP: begin
        emit_req  = 1'b1;
        em_status = {MSG_NOTE_ON, st_r[3:0]};
        em_d1     = note;
        em_d2     = d2_r;
        if (emit_ok) begin
          lw_we   = (cnt_sel < 4'(CHORD_TONES));
          lw_addr = laddr(cur_s, cnt_sel);
          lw_data = note;
          ow_we   = 1'b1;
          ow_addr = {cur, note};
          ow_data = cur_own;
        end
      end
      S_UPD_APP: begin
        lw_we   = (cnt_sel < 4'(CHORD_TONES));
        lw_addr = laddr(cur_s, cnt_sel);
        lw_data = note;
        ow_we   = 1'b1;
        ow_addr = {~cur, note};
        ow_data = cur_own;
      end
      S_OFF_RD, S_AT_RD: begin
        if (k != cnt_sel) begin
          lr_re   = 1'b1;
          lr_addr = laddr(cur_s, k);
        end
      end
      S_OFF_EM: begin
        emit_req  = 1'b1;
        em_status = {MSG_NOTE_OFF, st_r[3:0]};
        em_d1     = lr_data;
      end
      S_AT_EM: begin
        emit_req  = 1'b1;
        em_status = {MSG_POLY_AT, st_r[3:0]};
        em_d1     = lr_data;
        em_d2     = d2_r;
      end
      S_PASS: begin
        emit_req  = 1'b1;
        em_status = st_r;
        em_d1     = d1_r;
        em_d2     = d2_r;
      end
      S_REL: begin
        emit_req  = !scan[7] && old_v;
        em_status = {MSG_NOTE_OFF, last_channel};
        em_d1     = scan[6:0];
      end
      S_DOFF_CHK: begin
        if (!scan[7] && old_v) begin
          if (!new_v) begin
            emit_req  = 1'b1;
            em_status = {MSG_NOTE_OFF, last_channel};
            em_d1     = scan[6:0];
          end else begin
            or_re   = 1'b1;
            or_addr = {cur, scan[6:0]};
          end
        end
      end
      S_DOFF_RO: begin
        or_re   = 1'b1;
        or_addr = {~cur, scan[6:0]};
      end
      S_DOFF_EM: begin
        emit_req  = 1'b1;
        em_status = {MSG_NOTE_OFF, last_channel};
        em_d1     = scan[6:0];
      end
      S_DON_CHK: begin
        if (!scan[7] && new_v) begin
          or_re   = 1'b1;
          or_addr = {~cur, scan[6:0]};
        end
      end
      S_DON_RN: begin
        if (old_v) begin
          or_re   = 1'b1;
          or_addr = {cur, scan[6:0]};
        end
      end
      S_DON_EM: begin
        emit_req  = 1'b1;
        em_status = {MSG_NOTE_ON, last_channel};
        em_d1     = scan[6:0];
        em_d2     = slot_velocity[tmp_slot];
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer, slot state and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      chord_flags     <= '0;
      inversion_count <= '0;
      slot_valid      <= '0;
      own_vld[0]      <= '0;
      own_vld[1]      <= '0;
      cur             <= 1'b0;
      last_channel    <= '0;
      hold_vld        <= 1'b0;
      out_valid       <= 1'b0;
      emit_cnt        <= '0;
      for (int s = 0; s < MAX_ROOTS; s++) begin
        list_cnt[s] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_CHORD_FLAGS: chord_flags     <= cfg_data;
          REG_INVERSION:   inversion_count <= cfg_data[3:0];
          default: ;
        endcase
      end

      // output register drains on its transfer
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // a new result pushes the held one out, not marked last
      if (emit_fire && emit_cnt < 7'(RESULT_LIMIT)) begin
        if (hold_vld) begin
          out_valid    <= 1'b1;
          out_status   <= hold_status;
          out_data_one <= hold_d1;
          out_data_two <= hold_d2;
          last         <= 1'b0;
        end
        hold_vld    <= 1'b1;
        hold_status <= em_status;
        hold_d1     <= em_d1;
        hold_d2     <= em_d2;
        emit_cnt    <= emit_cnt + 7'd1;
      end
      // end of item: the held result is the last one
      if (flush_fire) begin
        out_valid    <= 1'b1;
        out_status   <= hold_status;
        out_data_one <= hold_d1;
        out_data_two <= hold_d2;
        last         <= 1'b1;
        hold_vld     <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            emit_cnt <= '0;
            st_r     <= status_byte;
            d1_r     <= data_one;
            d2_r     <= data_two;
            k        <= '0;
            case (op)
              OP_MIDI: begin
                if (in_type == MSG_NOTE_ON && data_two != 7'd0) begin
                  if (f_hit || f_free) begin
                    if (f_hit) begin
                      cur_s                     <= f_idx;
                      slot_velocity[f_idx]      <= data_two;
                      list_cnt[f_idx]           <= '0;
                    end else begin
                      cur_s                     <= f_free_idx;
                      slot_valid[f_free_idx]    <= 1'b1;
                      slot_root[f_free_idx]     <= data_one;
                      slot_age_rank[f_free_idx] <= SLOT_W'(used);
                      slot_velocity[f_free_idx] <= data_two;
                      list_cnt[f_free_idx]      <= '0;
                    end
                    last_channel <= status_byte[3:0];
                    is_upd       <= 1'b0;
                    bld_root     <= data_one;
                    rem          <= (ch_n == 4'd1) ? 4'd0 : inversion_count;
                    q12          <= '0;
                    pos          <= '0;
                    idx          <= '0;
                    state        <= S_BLD_DIV;
                  end
                end else if (in_type == MSG_NOTE_ON || in_type == MSG_NOTE_OFF) begin
                  if (f_hit) begin
                    cur_s <= f_idx;
                    state <= S_OFF_RD;
                  end
                end else if (in_type == MSG_POLY_AT) begin
                  if (f_hit) begin
                    cur_s                <= f_idx;
                    slot_velocity[f_idx] <= data_two;
                    state                <= S_AT_RD;
                  end
                end else begin
                  state <= S_PASS;
                end
              end
              OP_UPDATE: begin
                for (int s = 0; s < MAX_ROOTS; s++) begin
                  list_cnt[s] <= '0;
                end
                own_vld[~cur] <= '0;
                rk            <= '0;
                si            <= '0;
                is_upd        <= 1'b1;
                state         <= S_UPD_SLOT;
              end
              OP_RELEASE: begin
                scan  <= '0;
                state <= S_REL;
              end
              default: ;
            endcase
          end
        end

        // remainder and quotient*12 of the inversion by the chord length
        S_BLD_DIV: begin
          if (rem >= ch_n) begin
            rem <= rem - ch_n;
            q12 <= q12 + 8'd12;
          end else begin
            state <= S_BLD_TONE;
          end
        end

        S_BLD_TONE: begin
          if (pos == 4'(CHORD_TONES)) begin
            state <= is_upd ? S_UPD_SLOT : S_FLUSH;
          end else begin
            pos <= pos + 4'd1;
            if (pos_en) begin
              idx <= idx + 4'd1;
              if (tone_sum[8:7] == 2'b00) begin
                note  <= tone_sum[6:0];
                state <= S_TONE_OWN;
              end
            end
          end
        end

        // owner data is back: strip an owned note from its owner's list
        S_TONE_OWN: begin
          k <= '0;
          w <= '0;
          rm_s <= SLOT_W'(or_data - OWN_W'(1));
          if (own_vld[bld_bank][note] && !(is_upd && or_data == cur_own)) begin
            state <= S_RM_RD;
          end else begin
            state <= is_upd ? S_UPD_APP : S_NON_APP;
          end
        end

        S_RM_RD: begin
          if (k == cnt_sel) begin
            list_cnt[rm_s] <= w;
            state          <= is_upd ? S_UPD_APP : S_NON_APP;
          end else begin
            state <= S_RM_WR;
          end
        end

        S_RM_WR: begin
          if (lr_data != note) begin
            w <= w + 4'd1;
          end
          k     <= k + 4'd1;
          state <= S_RM_RD;
        end

        S_NON_APP: begin
          if (emit_ok) begin
            if (cnt_sel < 4'(CHORD_TONES)) begin
              list_cnt[cur_s] <= cnt_sel + 4'd1;
            end
            own_vld[cur][note] <= 1'b1;
            state              <= S_BLD_TONE;
          end
        end

        S_UPD_APP: begin
          if (cnt_sel < 4'(CHORD_TONES)) begin
            list_cnt[cur_s] <= cnt_sel + 4'd1;
          end
          own_vld[~cur][note] <= 1'b1;
          state               <= S_BLD_TONE;
        end

        // rebuild held chords, oldest root first
        S_UPD_SLOT: begin
          if (rk == SCNT_W'(MAX_ROOTS)) begin
            scan  <= '0;
            state <= S_DOFF_CHK;
          end else if (si == SCNT_W'(MAX_ROOTS)) begin
            si <= '0;
            rk <= rk + SCNT_W'(1);
          end else begin
            si <= si + SCNT_W'(1);
            if (slot_valid[si_i] && SCNT_W'(slot_age_rank[si_i]) == rk) begin
              cur_s    <= si_i;
              bld_root <= slot_root[si_i];
              rem      <= (ch_n == 4'd1) ? 4'd0 : inversion_count;
              q12      <= '0;
              pos      <= '0;
              idx      <= '0;
              state    <= S_BLD_DIV;
            end
          end
        end

        S_DOFF_CHK: begin
          if (scan[7]) begin
            scan  <= '0;
            state <= S_DON_CHK;
          end else if (!old_v) begin
            scan <= scan + 8'd1;
          end else if (!new_v) begin
            if (emit_ok) begin
              scan <= scan + 8'd1;
            end
          end else begin
            state <= S_DOFF_RO;
          end
        end

        S_DOFF_RO: begin
          tmp   <= or_data;
          state <= S_DOFF_RN;
        end

        S_DOFF_RN: begin
          if (or_data != tmp) begin
            state <= S_DOFF_EM;
          end else begin
            scan  <= scan + 8'd1;
            state <= S_DOFF_CHK;
          end
        end

        S_DOFF_EM: begin
          if (emit_ok) begin
            scan  <= scan + 8'd1;
            state <= S_DOFF_CHK;
          end
        end

        S_DON_CHK: begin
          if (scan[7]) begin
            cur   <= ~cur;
            state <= S_FLUSH;
          end else if (!new_v) begin
            scan <= scan + 8'd1;
          end else begin
            state <= S_DON_RN;
          end
        end

        S_DON_RN: begin
          tmp   <= or_data;
          state <= old_v ? S_DON_RO : S_DON_EM;
        end

        S_DON_RO: begin
          if (or_data != tmp) begin
            state <= S_DON_EM;
          end else begin
            scan  <= scan + 8'd1;
            state <= S_DON_CHK;
          end
        end

        S_DON_EM: begin
          if (emit_ok) begin
            scan  <= scan + 8'd1;
            state <= S_DON_CHK;
          end
        end

        S_OFF_RD: begin
          if (k == cnt_sel) begin
            list_cnt[cur_s] <= '0;
            for (int s = 0; s < MAX_ROOTS; s++) begin
              if (slot_valid[s] && SLOT_W'(s) != cur_s
                  && slot_age_rank[s] > slot_age_rank[cur_s]) begin
                slot_age_rank[s] <= slot_age_rank[s] - SLOT_W'(1);
              end
            end
            slot_valid[cur_s] <= 1'b0;
            state             <= S_FLUSH;
          end else begin
            state <= S_OFF_EM;
          end
        end

        S_OFF_EM: begin
          if (emit_ok) begin
            own_vld[cur][lr_data] <= 1'b0;
            k                     <= k + 4'd1;
            state                 <= S_OFF_RD;
          end
        end

        S_AT_RD: begin
          state <= (k == cnt_sel) ? S_FLUSH : S_AT_EM;
        end

        S_AT_EM: begin
          if (emit_ok) begin
            k     <= k + 4'd1;
            state <= S_AT_RD;
          end
        end

        S_PASS: begin
          if (emit_ok) begin
            state <= S_FLUSH;
          end
        end

        S_REL: begin
          if (scan[7]) begin
            own_vld[cur] <= '0;
            slot_valid   <= '0;
            for (int s = 0; s < MAX_ROOTS; s++) begin
              list_cnt[s] <= '0;
            end
            state <= S_FLUSH;
          end else if (!old_v || emit_ok) begin
            scan <= scan + 8'd1;
          end
        end

        S_FLUSH: begin
          if (!hold_vld || can_push) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `CME_ASSERT_IMP(a_idle_no_hold, state == S_IDLE, !hold_vld, "result held while idle")
  `CME_ASSERT_IMP(a_emit_cap, 1'b1, emit_cnt <= 7'(RESULT_LIMIT), "result count over limit")
  `CME_ASSERT_NEXT(a_flush_done, flush_fire, out_valid && last && !hold_vld, "flush lost last")

  for (genvar g = 0; g < MAX_ROOTS; g++) begin : g_chk
    `CME_ASSERT_IMP(a_list_cnt, 1'b1, list_cnt[g] <= 4'(CHORD_TONES), "chord list overflow")
  end

endmodule

// ----- sim/midi_chord_expander_checker.sv -----
module midi_chord_expander_checker
  import cme_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] status_byte,
  input  logic [6:0] data_one,
  input  logic [6:0] data_two,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_status,
  input  logic [6:0] out_data_one,
  input  logic [6:0] out_data_two,
  input  logic       last,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROOTS = 3;

  typedef struct {
    logic [7:0] st;
    logic [6:0] d1;
    logic [6:0] d2;
    logic       lst;
  } midi_msg_t;

  midi_msg_t  chord_msgs_q[$];
  int         msgs_this_item;

  logic [7:0] flags_r;
  logic [3:0] inv_r;
  logic       held[ROOTS];
  logic [6:0] root_note[ROOTS];
  logic [6:0] root_vel[ROOTS];
  logic [1:0] root_rank[ROOTS];
  logic [7:0] tones[ROOTS][CHORD_TONES];
  logic [2:0] owner[NOTE_COUNT];
  logic [3:0] chan_r;

  // emit one message, drop anything past the per-item cap
  function automatic void push_msg(input logic [7:0] st, input logic [6:0] d1,
                                   input logic [6:0] d2);
    midi_msg_t m;
    if (msgs_this_item >= RESULT_LIMIT) return;
    m.st = st; m.d1 = d1; m.d2 = d2; m.lst = 1'b0;
    chord_msgs_q.push_back(m);
    msgs_this_item++;
  endfunction

  function automatic int spell_chord(input logic [6:0] root,
                                     output logic [6:0] notes[CHORD_TONES]);
    int iv[CHORD_TONES];
    int n, cnt, q, r, t;
    n = 0; cnt = 0;
    foreach (notes[i]) notes[i] = '0;
    iv[n++] = 0;
    if (flags_r[0]) begin iv[n++] = 3; iv[n++] = 6; end
    if (flags_r[1]) begin iv[n++] = 3; iv[n++] = 7; end
    if (flags_r[2]) begin iv[n++] = 4; iv[n++] = 7; end
    if (flags_r[3]) begin iv[n++] = 5; iv[n++] = 7; end
    if (flags_r[4]) iv[n++] = 9;
    if (flags_r[5]) iv[n++] = 10;
    if (flags_r[6]) iv[n++] = 11;
    if (flags_r[7]) iv[n++] = 14;
    if (n <= 1) begin
      notes[0] = root;
      return 1;
    end
    q = int'(inv_r) / n;
    r = int'(inv_r) % n;
    for (int i = 0; i < n; i++) begin
      t = int'(root) + iv[i] + q * 12 + ((i < r) ? 12 : 0);
      if (t < 128) notes[cnt++] = t[6:0];
    end
    return cnt;
  endfunction

  function automatic int tone_count(input int s);
    int k;
    k = 0;
    while (k < CHORD_TONES && tones[s][k][7]) k++;
    return k;
  endfunction

  function automatic void drop_tone(input int s, input logic [6:0] note);
    logic [7:0] keep[CHORD_TONES];
    int c, k;
    c = tone_count(s);
    k = 0;
    foreach (keep[i]) keep[i] = '0;
    for (int i = 0; i < c; i++)
      if (tones[s][i][6:0] != note) keep[k++] = tones[s][i];
    tones[s] = keep;
  endfunction

  function automatic int find_root(input logic [6:0] root);
    for (int s = 0; s < ROOTS; s++)
      if (held[s] && root_note[s] == root) return s;
    return -1;
  endfunction

  function automatic void press(input logic [3:0] ch, input logic [6:0] root,
                                input logic [6:0] vel);
    logic [6:0] notes[CHORD_TONES];
    int f, used, k, cnt, c, s;
    logic [2:0] own;
    f = find_root(root);
    if (f < 0) begin
      used = 0;
      for (int i = 0; i < ROOTS; i++) if (held[i]) used++;
      k = 0;
      while (k < ROOTS && held[k]) k++;
      if (k >= ROOTS) return;
      f = k;
      held[k] = 1'b1;
      root_note[k] = root;
      root_rank[k] = used[1:0];
    end
    s = f;
    root_vel[s] = vel;
    chan_r = ch;
    foreach (tones[s][i]) tones[s][i] = '0;
    cnt = spell_chord(root, notes);
    for (int i = 0; i < cnt; i++) begin
      own = owner[notes[i]];
      if (own != 0 && own <= ROOTS) drop_tone(int'(own) - 1, notes[i]);
      c = tone_count(s);
      if (c < CHORD_TONES) tones[s][c] = {1'b1, notes[i]};
      owner[notes[i]] = 3'(s + 1);
      push_msg({MSG_NOTE_ON, ch}, notes[i], vel);
    end
  endfunction

  function automatic void lift(input logic [3:0] ch, input logic [6:0] root);
    int s, c;
    s = find_root(root);
    if (s < 0) return;
    c = tone_count(s);
    for (int i = 0; i < c; i++) begin
      push_msg({MSG_NOTE_OFF, ch}, tones[s][i][6:0], 7'd0);
      owner[tones[s][i][6:0]] = '0;
    end
    foreach (tones[s][i]) tones[s][i] = '0;
    for (int k = 0; k < ROOTS; k++)
      if (held[k] && k != s && root_rank[k] > root_rank[s]) root_rank[k]--;
    held[s] = 1'b0;
  endfunction

  function automatic void pressure(input logic [3:0] ch, input logic [6:0] root,
                                   input logic [6:0] p);
    int s, c;
    s = find_root(root);
    if (s < 0) return;
    root_vel[s] = p;
    c = tone_count(s);
    for (int i = 0; i < c; i++) push_msg({MSG_POLY_AT, ch}, tones[s][i][6:0], p);
  endfunction

  function automatic void revoice_all();
    logic [2:0] next_owner[NOTE_COUNT];
    logic [6:0] nl[ROOTS][CHORD_TONES];
    logic [6:0] notes[CHORD_TONES];
    int nc[ROOTS];
    int cnt, p, k;
    foreach (next_owner[i]) next_owner[i] = '0;
    foreach (nl[a, b]) nl[a][b] = '0;
    foreach (nc[i]) nc[i] = 0;
    for (int r = 0; r < ROOTS; r++)
      for (int s = 0; s < ROOTS; s++) begin
        if (!held[s] || root_rank[s] != r) continue;
        cnt = spell_chord(root_note[s], notes);
        for (int i = 0; i < cnt; i++) begin
          p = next_owner[notes[i]];
          if (p != 0) begin
            // strip every copy of the note from the previous owner's list
            k = 0;
            for (int j = 0; j < nc[p-1]; j++)
              if (nl[p-1][j] != notes[i]) nl[p-1][k++] = nl[p-1][j];
            nc[p-1] = k;
          end
          next_owner[notes[i]] = 3'(s + 1);
        end
        for (int i = 0; i < cnt; i++) nl[s][i] = notes[i];
        nc[s] = cnt;
      end
    for (int n = 0; n < NOTE_COUNT; n++)
      if (owner[n] != 0 && next_owner[n] != owner[n])
        push_msg({MSG_NOTE_OFF, chan_r}, 7'(n), 7'd0);
    for (int n = 0; n < NOTE_COUNT; n++)
      if (next_owner[n] != 0 && next_owner[n] != owner[n])
        push_msg({MSG_NOTE_ON, chan_r}, 7'(n), root_vel[next_owner[n] - 1]);
    owner = next_owner;
    foreach (tones[a, b]) tones[a][b] = '0;
    for (int s = 0; s < ROOTS; s++)
      if (held[s])
        for (int i = 0; i < nc[s]; i++) tones[s][i] = {1'b1, nl[s][i]};
  endfunction

  function automatic void release_every();
    for (int n = 0; n < NOTE_COUNT; n++)
      if (owner[n] != 0) push_msg({MSG_NOTE_OFF, chan_r}, 7'(n), 7'd0);
    foreach (owner[i]) owner[i] = '0;
    foreach (tones[a, b]) tones[a][b] = '0;
    foreach (held[i]) held[i] = 1'b0;
  endfunction

  function automatic void predict_item(input logic [1:0] o, input logic [7:0] st,
                                       input logic [6:0] d1, input logic [6:0] d2);
    midi_msg_t m;
    msgs_this_item = 0;
    if (o == OP_UPDATE) revoice_all();
    else if (o == OP_RELEASE) release_every();
    else if (o == OP_MIDI) begin
      if (st[7:4] == MSG_NOTE_ON && d2 != 0) press(st[3:0], d1, d2);
      else if (st[7:4] == MSG_NOTE_ON || st[7:4] == MSG_NOTE_OFF) lift(st[3:0], d1);
      else if (st[7:4] == MSG_POLY_AT) pressure(st[3:0], d1, d2);
      else push_msg(st, d1, d2);
    end
    if (msgs_this_item > 0) begin
      m = chord_msgs_q.pop_back();
      m.lst = 1'b1;
      chord_msgs_q.push_back(m);
    end
  endfunction

  always @(posedge clk) begin
    midi_msg_t e;
    if (rst) begin
      flags_r = '0;
      inv_r   = '0;
      chan_r  = '0;
      foreach (held[i]) held[i] = 1'b0;
      foreach (owner[i]) owner[i] = '0;
      foreach (tones[a, b]) tones[a][b] = '0;
      chord_msgs_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_CHORD_FLAGS) flags_r = cfg_data;
        else inv_r = cfg_data[3:0];
      end
      if (in_valid && in_ready) predict_item(op, status_byte, data_one, data_two);
      if (out_valid && out_ready) begin
        if (chord_msgs_q.size() == 0) begin
          $display("%0t: unexpected result: status %h data %h %h last %b", $time,
                   out_status, out_data_one, out_data_two, last);
          errors++;
        end else begin
          e = chord_msgs_q.pop_front();
          if (out_status !== e.st) begin
            $display("%0t: out_status expected %h actual %h", $time, e.st, out_status);
            errors++;
          end
          if (out_data_one !== e.d1) begin
            $display("%0t: out_data_one expected %h actual %h", $time, e.d1, out_data_one);
            errors++;
          end
          if (out_data_two !== e.d2) begin
            $display("%0t: out_data_two expected %h actual %h", $time, e.d2, out_data_two);
            errors++;
          end
          if (last !== e.lst) begin
            $display("%0t: last expected %b actual %b", $time, e.lst, last);
            errors++;
          end
        end
      end
    end
    pending = chord_msgs_q.size();
  end

endmodule

// ----- sim/midi_chord_expander_top_tb.sv -----
module midi_chord_expander_top_tb;
  import cme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Long enough for the worst update, with margin, on every quiet wait.
  localparam int DRAIN_CYCLES = 1300;
  // Quiet cycles tolerated before the run is declared hung: covers a long
  // receiver hold, a full update and the drain pause several times over.
  localparam int HANG_LIMIT   = 20000;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] op;
  logic [7:0] status_byte;
  logic [6:0] data_one;
  logic [6:0] data_two;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_status;
  logic [6:0] out_data_one;
  logic [6:0] out_data_two;
  logic       last;

  int         errors;
  int         pending;
  bit         gaps_on = 1'b1;   // random idling on both sides
  bit         hold_req = 1'b0;  // ask the receiver for one long hold
  int         hold_left = 0;
  int         quiet_cycles = 0;
  logic [6:0] recent_roots[6];

  always #5 clk = ~clk;

  midi_chord_expander_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .status_byte(status_byte),
    .data_one(data_one), .data_two(data_two),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_data_one(out_data_one), .out_data_two(out_data_two), .last(last)
  );

  midi_chord_expander_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .status_byte(status_byte),
    .data_one(data_one), .data_two(data_two),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_data_one(out_data_one), .out_data_two(out_data_two), .last(last),
    .errors(errors), .pending(pending)
  );

  // Receiver: random ready, or a counted hold while the sender keeps pushing
  // so the block backs up and drops in_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !gaps_on || ($urandom_range(0, 99) >= 7);
    end
  end

  // Hang detector: count cycles with no transfer on any port.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("midi_chord_expander_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item; valid stays up across back-to-back transfers.
  task automatic send(input logic [1:0] o, input logic [7:0] st,
                      input logic [6:0] d1, input logic [6:0] d2);
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    status_byte <= st;
    data_one    <= d1;
    data_two    <= d2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic note(input logic [3:0] kind, input logic [3:0] ch,
                      input logic [6:0] d1, input logic [6:0] d2);
    send(OP_MIDI, {kind, ch}, d1, d2);
  endtask

  // Drop valid, wait until every expected result is back, then let any
  // silent work finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both chord registers while idle, then revoice the held roots.
  task automatic retune(input logic [7:0] flags, input logic [3:0] inv);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CHORD_FLAGS;
    cfg_data  <= flags;
    @(posedge clk);
    cfg_index <= REG_INVERSION;
    cfg_data  <= {4'd0, inv};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    send(OP_UPDATE, 8'h00, 7'd0, 7'd0);
  endtask

  // Mostly well-formed note traffic around a few recent roots, plus noise.
  task automatic play_random(input int count);
    int pick;
    logic [6:0] root;
    logic [7:0] st;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      root = recent_roots[$urandom_range(0, 5)];
      if (pick < 35) begin
        root = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(36, 90));
        recent_roots[$urandom_range(0, 5)] = root;
        note(MSG_NOTE_ON, 4'($urandom), root, 7'($urandom_range(1, 127)));
      end else if (pick < 55) begin
        note(($urandom_range(0, 1) != 0) ? MSG_NOTE_OFF : MSG_NOTE_ON,
             4'($urandom), root, ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom));
      end else if (pick < 65) begin
        note(MSG_POLY_AT, 4'($urandom), root, 7'($urandom));
      end else if (pick < 73) begin
        send(OP_UPDATE, 8'($urandom), 7'($urandom), 7'($urandom));
      end else if (pick < 78) begin
        send(OP_RELEASE, 8'($urandom), 7'($urandom), 7'($urandom));
      end else if (pick < 82) begin
        send(2'd3, 8'($urandom), 7'($urandom), 7'($urandom));
      end else begin
        st = 8'($urandom);
        send(OP_MIDI, st, 7'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= REG_CHORD_FLAGS;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    op          <= OP_MIDI;
    status_byte <= '0;
    data_one    <= '0;
    data_two    <= '0;
    foreach (recent_roots[i]) recent_roots[i] = 7'(60 + i);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: every chord is the root alone.
    note(MSG_NOTE_ON, 4'h0, 7'd0, 7'd127);
    note(MSG_NOTE_OFF, 4'hF, 7'd0, 7'd127);

    // Dominant seventh shape, no inversion.
    retune(8'h24, 4'd0);
    note(MSG_NOTE_ON, 4'h3, 7'd60, 7'd100);
    note(MSG_NOTE_ON, 4'h5, 7'd127, 7'd1);     // top tones drop off
    note(MSG_NOTE_ON, 4'h1, 7'd64, 7'd90);     // steals note 64 of root 60
    note(MSG_NOTE_ON, 4'h2, 7'd30, 7'd20);     // fourth root is ignored
    note(MSG_POLY_AT, 4'h7, 7'd60, 7'd55);
    note(MSG_POLY_AT, 4'h7, 7'd5, 7'd55);      // unheld root: silent
    note(MSG_NOTE_ON, 4'h4, 7'd60, 7'd77);     // re-press of a held root
    note(MSG_NOTE_ON, 4'h9, 7'd127, 7'd0);     // zero velocity is a release
    note(MSG_NOTE_OFF, 4'h0, 7'd5, 7'd0);      // unheld root: silent
    send(OP_MIDI, 8'hB5, 7'd127, 7'd0);        // pass-through
    send(OP_MIDI, 8'hFF, 7'd0, 7'd127);
    send(OP_MIDI, 8'h00, 7'd85, 7'd42);
    send(2'd3, 8'h90, 7'd10, 7'd10);           // unused op
    send(OP_UPDATE, 8'h00, 7'd0, 7'd0);
    send(OP_RELEASE, 8'h00, 7'd0, 7'd0);

    // Every interval with the deepest inversion; duplicates and big drops.
    retune(8'hFF, 4'd15);
    note(MSG_NOTE_ON, 4'h2, 7'd20, 7'd64);
    note(MSG_NOTE_ON, 4'h6, 7'd22, 7'd32);
    send(OP_UPDATE, 8'h00, 7'd0, 7'd0);
    note(MSG_NOTE_OFF, 4'h6, 7'd20, 7'd0);
    send(OP_RELEASE, 8'h00, 7'd0, 7'd0);

    // Random phases, each under its own chord setting.
    retune(8'h0F, 4'd12);
    hold_req = 1'b1;                           // receiver backs up once
    play_random(90);

    retune(8'($urandom), 4'($urandom));
    gaps_on = 1'b0;                            // a stretch at full rate
    play_random(90);
    gaps_on = 1'b1;

    settle();                                  // sender waits for a clean drain
    play_random(20);

    retune(8'($urandom), 4'($urandom_range(0, 12)));
    play_random(80);

    retune(8'h01, 4'd1);
    play_random(80);
    send(OP_RELEASE, 8'h00, 7'd0, 7'd0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("midi_chord_expander_top: match");
    end else begin
      $display("midi_chord_expander_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/cme_pkg.sv
hdl/cme_ram.sv
hdl/midi_chord_expander_top.sv
sim/midi_chord_expander_checker.sv
sim/midi_chord_expander_top_tb.sv
